// ===== hdl/tse_pkg.sv =====
// ----------------------------------------------------------------------------
// tse_pkg : shared types and constants of the TLS SNI extractor
// Parse phases, result layout and the word passed from parser to emitter.
// ----------------------------------------------------------------------------
`default_nettype none
package tse_pkg;

  localparam int POSITION_BITS = 18;
  localparam logic [POSITION_BITS-1:0] POS_MAX = {POSITION_BITS{1'b1}};
  localparam logic [7:0] CT_HANDSHAKE = 8'd22;
  localparam logic [7:0] HS_CLIENT_HELLO = 8'd1;
  localparam logic [7:0] MAJOR_TLS = 8'd3;
  localparam logic [POSITION_BITS-1:0] SID_POSITION = POSITION_BITS'(6 + 3 + 2 + 32);
  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_SHORT = 2'd1;
  localparam logic [1:0] ST_BAD_VERSION = 2'd2;
  localparam int OUT_DATA_BITS = 72;
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_ABITS = 2;

  typedef logic [POSITION_BITS-1:0] pos_t;

  typedef enum logic [3:0] {
    PH_HEADER  = 4'd0,
    PH_SID     = 4'd1,
    PH_CS_HI   = 4'd2,
    PH_CS_LO   = 4'd3,
    PH_CM      = 4'd4,
    PH_EXTS_HI = 4'd5,
    PH_EXTS_LO = 4'd6,
    PH_TYPE_HI = 4'd7,
    PH_TYPE_LO = 4'd8,
    PH_ELEN_HI = 4'd9,
    PH_ELEN_LO = 4'd10,
    PH_NLEN_HI = 4'd11,
    PH_NLEN_LO = 4'd12,
    PH_NAME    = 4'd13,
    PH_DONE    = 4'd14
  } phase_t;

  // one classified byte: a name byte and/or a packet summary
  typedef struct packed {
    logic        name_valid;
    logic [7:0]  name_byte;
    logic        sum_valid;
    logic [1:0]  status;
    logic        is_https;
    logic [7:0]  rec_type;
    logic [7:0]  version_minor;
    logic [15:0] record_length;
    logic        handshake_present;
    logic [7:0]  hs_msg_type;
    logic        sni_found;
    logic [15:0] sni_length;
  } event_t;

  function automatic pos_t sat_add(input pos_t a, input logic [16:0] b);
    logic [POSITION_BITS:0] s;
    begin
      s = {1'b0, a} + (POSITION_BITS+1)'(b);
      sat_add = s[POSITION_BITS] ? POS_MAX : s[POSITION_BITS-1:0];
    end
  endfunction

endpackage
`default_nettype wire

// ===== hdl/tse_parser.sv =====
// ----------------------------------------------------------------------------
// tse_parser : front end of the TLS SNI extractor
// Track byte position and parse phase; classify each byte into an event.
// ----------------------------------------------------------------------------
`default_nettype none
module tse_parser (
  input  wire              clk,
  input  wire              rst_n,
  input  wire              in_valid,
  input  wire [7:0]        in_byte,
  input  wire              in_eop,
  input  wire              in_https,
  output tse_pkg::event_t  ev
);
  import tse_pkg::*;

  pos_t        pos_r, pos_nxt, nfp_r, nfp_nxt, ext_end_r, ext_end_nxt;
  pos_t        next_end_r, next_end_nxt, name_end_r, name_end_nxt;
  phase_t      ph_r, ph_nxt;
  logic [7:0]  lhb_r, lhb_nxt, hsb_r, hsb_nxt;
  logic [39:0] hdr_r, hdr_nxt;
  logic [15:0] nlen_r, nlen_nxt;
  logic        seen_r, seen_nxt;
  pos_t        nx;
  logic [15:0] v16;
  pos_t        cnt;
  logic        found, hs;

  always_comb begin
    pos_nxt = pos_r; nfp_nxt = nfp_r; ext_end_nxt = ext_end_r;
    next_end_nxt = next_end_r; name_end_nxt = name_end_r; ph_nxt = ph_r;
    lhb_nxt = lhb_r; hsb_nxt = hsb_r; hdr_nxt = hdr_r; nlen_nxt = nlen_r;
    seen_nxt = seen_r;
    nx = sat_add(pos_r, 17'd1);
    v16 = {lhb_r, in_byte};
    ev = '0;
    cnt = nx;
    hs = 1'b0; found = 1'b0;
    if (in_valid) begin
      if (pos_r != POS_MAX) begin
        if (ph_r == PH_HEADER) begin
          if (pos_r < pos_t'(5)) begin
            hdr_nxt[8*pos_r[2:0] +: 8] = in_byte;
          end else if (pos_r == pos_t'(5)) begin
            hsb_nxt = in_byte;
            if (hdr_r[7:0] == CT_HANDSHAKE && hdr_r[15:8] == MAJOR_TLS &&
                in_byte == HS_CLIENT_HELLO) begin
              ph_nxt = PH_SID;
              nfp_nxt = SID_POSITION;
            end else begin
              ph_nxt = PH_DONE;
            end
          end
        end else if (ph_r != PH_DONE && pos_r == nfp_r) begin
          nfp_nxt = nx;
          unique case (ph_r)
            PH_SID: begin
              nfp_nxt = sat_add(nx, {9'd0, in_byte}); ph_nxt = PH_CS_HI;
            end
            PH_CS_HI, PH_EXTS_HI, PH_TYPE_HI, PH_ELEN_HI, PH_NLEN_HI: begin
              lhb_nxt = in_byte; ph_nxt = phase_t'(ph_r + 4'd1);
            end
            PH_CS_LO: begin
              nfp_nxt = sat_add(nx, {1'b0, v16}); ph_nxt = PH_CM;
            end
            PH_CM: begin
              nfp_nxt = sat_add(nx, {9'd0, in_byte}); ph_nxt = PH_EXTS_HI;
            end
            PH_EXTS_LO: begin
              ext_end_nxt = sat_add(nx, {1'b0, v16});
              ph_nxt = (v16 == 16'd0) ? PH_DONE : PH_TYPE_HI;
            end
            PH_TYPE_LO: begin
              nlen_nxt = v16; ph_nxt = PH_ELEN_HI;
            end
            PH_ELEN_LO: begin
              if (nlen_r == 16'd0 && v16 >= 16'd5) begin
                next_end_nxt = sat_add(nx, {1'b0, v16});
                nfp_nxt = sat_add(nx, 17'd3);
                ph_nxt = PH_NLEN_HI;
              end else begin
                nfp_nxt = sat_add(nx, {1'b0, v16});
                ph_nxt = (nfp_nxt >= ext_end_r) ? PH_DONE : PH_TYPE_HI;
              end
            end
            PH_NLEN_LO: begin
              nlen_nxt = v16;
              name_end_nxt = sat_add(nx, {1'b0, v16});
              seen_nxt = 1'b1;
              ph_nxt = (v16 == 16'd0) ? PH_DONE : PH_NAME;
            end
            PH_NAME: begin
              ev.name_valid = 1'b1;
              ev.name_byte = in_byte;
              if (nx >= name_end_r) ph_nxt = PH_DONE;
            end
            default: ph_nxt = PH_DONE;
          endcase
        end
      end
      pos_nxt = nx;
      if (in_eop) begin
        ev.sum_valid = 1'b1;
        if (cnt < pos_t'(5)) begin
          ev.status = ST_SHORT; ev.is_https = in_https;
        end else if (hdr_nxt[15:8] != MAJOR_TLS) begin
          ev.status = ST_BAD_VERSION;
        end else begin
          hs = hdr_nxt[7:0] == CT_HANDSHAKE && cnt >= pos_t'(6);
          found = seen_nxt && next_end_nxt <= cnt && name_end_nxt <= cnt;
          ev.status = ST_OK;
          ev.is_https = in_https;
          ev.rec_type = hdr_nxt[7:0];
          ev.version_minor = hdr_nxt[23:16];
          ev.record_length = {hdr_nxt[31:24], hdr_nxt[39:32]};
          ev.handshake_present = hs;
          ev.hs_msg_type = hs ? hsb_nxt : 8'd0;
          ev.sni_found = found;
          ev.sni_length = found ? nlen_nxt : 16'd0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (in_valid && in_eop)) begin
      pos_r <= '0; nfp_r <= '0; ext_end_r <= '0; next_end_r <= '0;
      name_end_r <= '0; ph_r <= PH_HEADER; lhb_r <= '0; hsb_r <= '0;
      hdr_r <= '0; nlen_r <= '0; seen_r <= 1'b0;
    end else begin
      pos_r <= pos_nxt; nfp_r <= nfp_nxt; ext_end_r <= ext_end_nxt;
      next_end_r <= next_end_nxt; name_end_r <= name_end_nxt; ph_r <= ph_nxt;
      lhb_r <= lhb_nxt; hsb_r <= hsb_nxt; hdr_r <= hdr_nxt;
      nlen_r <= nlen_nxt; seen_r <= seen_nxt;
    end
  end

`ifndef SYNTHESIS
  a_name_only_in_name_phase: assert property (@(posedge clk) disable iff (!rst_n)
    ev.name_valid |-> ph_r == PH_NAME) else $error("name byte outside name phase");
  a_pos_monotone: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_eop) |=> pos_r >= $past(pos_r)) else $error("position went back");
  a_seen_implies_phase: assert property (@(posedge clk) disable iff (!rst_n)
    (ph_r == PH_NAME) |-> seen_r) else $error("name phase without length");
`endif
endmodule
`default_nettype wire

// ===== hdl/tse_emitter.sv =====
// ----------------------------------------------------------------------------
// tse_emitter : back end of the TLS SNI extractor
// Queue events and serialize them into result words, name byte first.
// ----------------------------------------------------------------------------
`default_nettype none
module tse_emitter (
  input  wire              clk,
  input  wire              rst_n,
  input  wire              ev_push,
  input  wire tse_pkg::event_t ev,
  output logic             ev_room,
  output logic             out_tvalid,
  input  wire              out_tready,
  output logic [tse_pkg::OUT_DATA_BITS-1:0] out_tdata,
  output logic             out_tlast,
  output logic             out_tuser
);
  import tse_pkg::*;

  event_t q_r [QUEUE_DEPTH];
  logic [QUEUE_ABITS-1:0] wr_r, rd_r;
  logic [QUEUE_ABITS:0]   cnt_r;
  logic                   name_done_r;
  event_t                 head;
  logic                   pop, beat, head_name;

  assign head = q_r[rd_r];
  assign head_name = head.name_valid && !name_done_r;
  // accept while a slot is free
  assign ev_room = cnt_r < (QUEUE_ABITS+1)'(QUEUE_DEPTH);
  assign out_tvalid = cnt_r != '0;
  assign beat = out_tvalid && out_tready;
  assign pop = beat && (!head_name || !head.sum_valid);

  always_comb begin
    out_tdata = '0;
    if (head_name) begin
      out_tdata[7:0] = head.name_byte;
      out_tuser = 1'b0;
      out_tlast = 1'b0;
    end else begin
      out_tdata[9:8]   = head.status;
      out_tdata[10]    = head.is_https;
      out_tdata[18:11] = head.rec_type;
      out_tdata[26:19] = head.version_minor;
      out_tdata[42:27] = head.record_length;
      out_tdata[43]    = head.handshake_present;
      out_tdata[51:44] = head.hs_msg_type;
      out_tdata[52]    = head.sni_found;
      out_tdata[68:53] = head.sni_length;
      out_tuser = 1'b1;
      out_tlast = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ev_push) q_r[wr_r] <= ev;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r <= '0; rd_r <= '0; cnt_r <= '0; name_done_r <= 1'b0;
    end else begin
      if (ev_push) wr_r <= wr_r + 1'b1;
      if (pop) rd_r <= rd_r + 1'b1;
      cnt_r <= cnt_r + (QUEUE_ABITS+1)'(ev_push) - (QUEUE_ABITS+1)'(pop);
      if (pop) name_done_r <= 1'b0;
      else if (beat) name_done_r <= 1'b1;
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    ev_push |-> cnt_r < (QUEUE_ABITS+1)'(QUEUE_DEPTH)) else $error("queue overflow");
  a_split_pair: assert property (@(posedge clk) disable iff (!rst_n)
    (beat && !pop) |=> out_tvalid && out_tuser) else $error("summary lost");
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= (QUEUE_ABITS+1)'(QUEUE_DEPTH)) else $error("count out of range");
`endif
endmodule
`default_nettype wire

// ===== hdl/tls_record_sni_extractor.sv =====
// The event of each byte is registered into the event queue, which offers its result word.
// Throughput: one byte per cycle while the event queue has room; the parser is a combinational compare/add step.
// A name byte that also ends a packet yields two words, the name byte first, then the summary.
// The four-entry event queue decouples the parser from the output stall.
// Reset (rst_n low, synchronous) clears the parse state and empties the queue.
// ----------------------------------------------------------------------------
// tls_record_sni_extractor : TLS ClientHello server name extractor
// Parse the record header and walk ClientHello extensions, emitting SNI bytes
// and a per-packet summary word.
// ----------------------------------------------------------------------------
`default_nettype none
module tls_record_sni_extractor (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_tvalid,
  output logic        in_tready,
  input  wire  [7:0]  in_tdata,   // data_byte
  input  wire         in_tlast,   // end_of_packet
  input  wire         in_tuser,   // port_https
  output logic        out_tvalid,
  input  wire         out_tready,
  // name_byte[7:0] status[9:8] is_https[10] record type[18:11]
  // version_minor[26:19] record_length[42:27] handshake_present[43]
  // handshake message type[51:44] sni_found[52] sni_length[68:53] zero pad to 72
  output logic [tse_pkg::OUT_DATA_BITS-1:0] out_tdata,
  output logic        out_tlast,  // last
  output logic        out_tuser   // kind
);
  import tse_pkg::*;

  event_t ev;
  logic   room, acc;

  // accept while the queue has room; each accepted byte may push one event
  assign in_tready = room;
  assign acc = in_tvalid && in_tready;

  tse_parser u_parser (
    .clk(clk), .rst_n(rst_n), .in_valid(acc), .in_byte(in_tdata),
    .in_eop(in_tlast), .in_https(in_tuser), .ev(ev)
  );

  tse_emitter u_emitter (
    .clk(clk), .rst_n(rst_n), .ev_push(ev.name_valid || ev.sum_valid), .ev(ev),
    .ev_room(room), .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tlast(out_tlast), .out_tuser(out_tuser)
  );

`ifndef SYNTHESIS
  a_push_needs_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (ev.name_valid || ev.sum_valid) |-> acc) else $error("event without byte");
  a_eop_gives_summary: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && in_tlast) |-> ev.sum_valid) else $error("summary missing");
  a_last_is_summary: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tlast == out_tuser) else $error("last without summary");
`endif
endmodule
`default_nettype wire

// ===== sim/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench : self-checking bench for tls_record_sni_extractor
// Streams TLS payload bytes, mostly well-formed ClientHello packets with random
// content, predicts name bytes and per-packet summaries, and compares words.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module testbench;
  import tse_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int TARGET_BYTES = 720;

  typedef struct packed {
    logic        kind;
    logic [7:0]  name_byte;
    logic [1:0]  status;
    logic        is_https;
    logic [7:0]  rec_type;
    logic [7:0]  version_minor;
    logic [15:0] record_length;
    logic        handshake_present;
    logic [7:0]  hs_msg_type;
    logic        sni_found;
    logic [15:0] sni_length;
    logic        last;
  } sni_word_t;

  logic clk;
  logic rst_n;
  logic in_tvalid;
  logic in_tready;
  logic [7:0] in_tdata;    // data_byte
  logic in_tlast;          // end_of_packet
  logic in_tuser;          // port_https
  logic out_tvalid;
  logic out_tready;
  logic [OUT_DATA_BITS-1:0] out_tdata;  // name_byte .. sni_length, see dut
  logic out_tlast;         // last
  logic out_tuser;         // kind

  tls_record_sni_extractor dut (.*);

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Predictor: a software copy of the parse state
  // --------------------------------------------------------------------------
  pos_t       pr_pos, pr_next, pr_ext_end, pr_name_ext_end, pr_name_end;
  phase_t     pr_phase;
  logic [7:0] pr_len_hi, pr_hs_byte;
  logic [7:0] pr_hdr [5];
  logic [15:0] pr_name_len;
  logic       pr_name_seen;

  sni_word_t  sni_expected [$];
  int         mismatches;
  int         quiet_cycles;
  int         stall_left;
  bit         no_idle;

  function automatic pos_t pos_add(input pos_t a, input int unsigned b);
    logic [31:0] s;
    s = 32'(a) + b;
    return (s > 32'(POS_MAX)) ? POS_MAX : pos_t'(s);
  endfunction

  task automatic clear_packet();
    pr_pos = '0; pr_next = '0; pr_ext_end = '0; pr_name_ext_end = '0;
    pr_name_end = '0; pr_phase = PH_HEADER; pr_len_hi = '0; pr_hs_byte = '0;
    pr_name_len = '0; pr_name_seen = 1'b0;
    for (int i = 0; i < 5; i++) pr_hdr[i] = '0;
  endtask

  // advance the parser by one byte and queue the words it causes
  task automatic predict_byte(input logic [7:0] b, input logic eop, input logic https);
    pos_t p, nx, cnt;
    logic [15:0] v16;
    sni_word_t w;
    p = pr_pos;
    if (p != POS_MAX) begin
      if (pr_phase == PH_HEADER) begin
        if (p < 5) pr_hdr[p[2:0]] = b;
        else if (p == 5) begin
          pr_hs_byte = b;
          if (pr_hdr[0] == CT_HANDSHAKE && pr_hdr[1] == MAJOR_TLS && b == HS_CLIENT_HELLO)
          begin
            pr_phase = PH_SID;
            pr_next = SID_POSITION;
          end else pr_phase = PH_DONE;
        end
      end else if (pr_phase != PH_DONE && p == pr_next) begin
        nx = pos_add(p, 1);
        v16 = {pr_len_hi, b};
        pr_next = nx;
        case (pr_phase)
          PH_SID: begin pr_next = pos_add(nx, b); pr_phase = PH_CS_HI; end
          PH_CS_HI, PH_EXTS_HI, PH_TYPE_HI, PH_ELEN_HI, PH_NLEN_HI: begin
            pr_len_hi = b;
            pr_phase = phase_t'(pr_phase + 1);
          end
          PH_CS_LO: begin pr_next = pos_add(nx, v16); pr_phase = PH_CM; end
          PH_CM: begin pr_next = pos_add(nx, b); pr_phase = PH_EXTS_HI; end
          PH_EXTS_LO: begin
            pr_ext_end = pos_add(nx, v16);
            pr_phase = (v16 == 0) ? PH_DONE : PH_TYPE_HI;
          end
          PH_TYPE_LO: begin pr_name_len = v16; pr_phase = PH_ELEN_HI; end
          PH_ELEN_LO: begin
            if (pr_name_len == 0 && v16 >= 5) begin
              pr_name_ext_end = pos_add(nx, v16);
              pr_next = pos_add(nx, 3);
              pr_phase = PH_NLEN_HI;
            end else begin
              pr_next = pos_add(nx, v16);
              pr_phase = (pr_next >= pr_ext_end) ? PH_DONE : PH_TYPE_HI;
            end
          end
          PH_NLEN_LO: begin
            pr_name_len = v16;
            pr_name_end = pos_add(nx, v16);
            pr_name_seen = 1'b1;
            pr_phase = (v16 == 0) ? PH_DONE : PH_NAME;
          end
          PH_NAME: begin
            w = '0;
            w.name_byte = b;
            sni_expected = {sni_expected, w};
            if (nx >= pr_name_end) pr_phase = PH_DONE;
          end
          default: pr_phase = PH_DONE;
        endcase
      end
    end
    pr_pos = pos_add(p, 1);
    if (eop) begin
      cnt = pr_pos;
      w = '0;
      w.kind = 1'b1;
      w.last = 1'b1;
      if (cnt < 5) begin
        w.status = ST_SHORT;
        w.is_https = https;
      end else if (pr_hdr[1] != MAJOR_TLS) begin
        w.status = ST_BAD_VERSION;
      end else begin
        w.status = ST_OK;
        w.is_https = https;
        w.rec_type = pr_hdr[0];
        w.version_minor = pr_hdr[2];
        w.record_length = {pr_hdr[3], pr_hdr[4]};
        w.handshake_present = (pr_hdr[0] == CT_HANDSHAKE) && cnt >= 6;
        w.hs_msg_type = w.handshake_present ? pr_hs_byte : 8'd0;
        w.sni_found = pr_name_seen && pr_name_ext_end <= cnt && pr_name_end <= cnt;
        w.sni_length = w.sni_found ? pr_name_len : 16'd0;
      end
      sni_expected = {sni_expected, w};
      clear_packet();
    end
  endtask

  // --------------------------------------------------------------------------
  // Sender: drive one byte at the falling edge, hold until accepted
  // --------------------------------------------------------------------------
  task automatic send_byte(input logic [7:0] b, input logic eop, input logic https);
    int gap;
    if (!no_idle && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 9);
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= b;
    in_tlast <= eop;
    in_tuser <= https;
    do @(posedge clk); while (!in_tready);
    predict_byte(b, eop, https);
    @(negedge clk);
  endtask

  task automatic send_packet(ref logic [7:0] pkt [$], input logic https);
    foreach (pkt[i]) send_byte(pkt[i], i == pkt.size() - 1, https);
  endtask

  // build a ClientHello with random content; garble picks a broken variant
  task automatic build_hello(ref logic [7:0] pkt [$], input int garble);
    int sid_len, cs_len, cm_len, nm_len, ext_len, pad_len, cut;
    pkt.delete();
    sid_len = $urandom_range(0, 4);
    cs_len = 2 * $urandom_range(1, 3);
    cm_len = $urandom_range(1, 2);
    nm_len = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 12);
    pad_len = $urandom_range(0, 1) ? $urandom_range(0, 3) : -1;
    pkt = {CT_HANDSHAKE, MAJOR_TLS, 8'($urandom), 8'($urandom), 8'($urandom),
           HS_CLIENT_HELLO};
    repeat (37) pkt = {pkt, 8'($urandom)};
    pkt = {pkt, 8'(sid_len)};
    repeat (sid_len) pkt = {pkt, 8'($urandom)};
    pkt = {pkt, 8'(cs_len >> 8), 8'(cs_len)};
    repeat (cs_len) pkt = {pkt, 8'($urandom)};
    pkt = {pkt, 8'(cm_len)};
    repeat (cm_len) pkt = {pkt, 8'($urandom)};
    ext_len = 9 + nm_len + ((pad_len >= 0) ? 4 + pad_len : 0);
    pkt = {pkt, 8'(ext_len >> 8), 8'(ext_len)};
    if (pad_len >= 0) begin
      pkt = {pkt, 8'd0, 8'd21};   // padding extension first
      pkt = {pkt, 8'd0, 8'(pad_len)};
      repeat (pad_len) pkt = {pkt, 8'($urandom)};
    end
    pkt = {pkt, 8'd0, 8'd0};       // server_name
    pkt = {pkt, 8'd0};
    pkt = {pkt, 8'((garble == 3) ? 2 : 5 + nm_len)};
    pkt = {pkt, 8'd0, 8'(3 + nm_len)};
    pkt = {pkt, 8'd0};
    pkt = {pkt, 8'(nm_len >> 8)};
    pkt = {pkt, 8'((garble == 4) ? nm_len + 6 : nm_len)};
    repeat (nm_len) pkt = {pkt, 8'($urandom)};
    repeat ($urandom_range(0, 3)) pkt = {pkt, 8'($urandom)};
    if (garble == 1) begin
      cut = $urandom_range(1, pkt.size());
      pkt = pkt[0:cut-1];
    end else if (garble == 2) begin
      pkt[$urandom_range(0, pkt.size() - 1)] = 8'($urandom);
    end
  endtask

  // --------------------------------------------------------------------------
  // Receiver: stalls out_tready at random, check each word in order
  // --------------------------------------------------------------------------
  always @(negedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      stall_left = 0;
    end else if (no_idle) out_tready <= 1'b1;
    else if (stall_left > 0) begin
      stall_left = stall_left - 1;
      out_tready <= 1'b0;
    end else if ($urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(0, 8);
      out_tready <= 1'b0;
    end else out_tready <= 1'b1;
  end

  always @(posedge clk) begin
    sni_word_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got = '0;
      got.kind = out_tuser;
      got.last = out_tlast;
      {got.sni_length, got.sni_found, got.hs_msg_type, got.handshake_present,
       got.record_length, got.version_minor, got.rec_type, got.is_https,
       got.status, got.name_byte} = out_tdata[68:0];
      if (out_tdata[71:69] != '0) begin
        mismatches++;
        if (mismatches <= 10) $display("pad bits not zero: %h", out_tdata);
      end
      if (sni_expected.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected word: %p", got);
      end else begin
        want = sni_expected.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10) $display("word mismatch: expected %p actual %p", want, got);
        end
      end
    end
  end

  // watchdog: cycles with no handshake on either side
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  typedef struct {
    logic [7:0] data;
    logic       eop;
    logic       https;
    logic       has_sum;     // typed-in summary for this row
    logic [1:0] sum_status;
    logic       sum_https;
  } row_t;

  row_t directed [22] = '{
    // one-byte packets: too short, https passes through
    '{8'hff, 1'b1, 1'b1, 1'b1, ST_SHORT, 1'b1},
    '{8'h00, 1'b1, 1'b0, 1'b1, ST_SHORT, 1'b0},
    // four bytes: still short
    '{8'd22, 1'b0, 1'b0, 1'b0, ST_OK, 1'b0}, '{8'd3, 1'b0, 1'b0, 1'b0, ST_OK, 1'b0},
    '{8'd1, 1'b0, 1'b0, 1'b0, ST_OK, 1'b0},
    '{8'd0, 1'b1, 1'b1, 1'b1, ST_SHORT, 1'b1},
    // five bytes, major version 2: bad version, https cleared
    '{8'd22, 1'b0, 1'b0, 1'b0, ST_OK, 1'b0}, '{8'd2, 1'b0, 1'b0, 1'b0, ST_OK, 1'b0},
    '{8'd1, 1'b0, 1'b0, 1'b0, ST_OK, 1'b0},
    '{8'd0, 1'b0, 1'b0, 1'b0, ST_OK, 1'b0},
    '{8'hff, 1'b1, 1'b1, 1'b1, ST_BAD_VERSION, 1'b0},
    // five-byte header, not a handshake: ok, predictor fills the rest
    '{8'd23, 1'b0, 1'b0, 1'b0, ST_OK, 1'b0}, '{8'd3, 1'b0, 1'b0, 1'b0, ST_OK, 1'b0},
    '{8'hff, 1'b0, 1'b0, 1'b0, ST_OK, 1'b0},
    '{8'hff, 1'b0, 1'b0, 1'b0, ST_OK, 1'b0}, '{8'hff, 1'b1, 1'b1, 1'b0, ST_OK, 1'b0},
    // six bytes, handshake but not ClientHello
    '{8'd22, 1'b0, 1'b0, 1'b0, ST_OK, 1'b0}, '{8'd3, 1'b0, 1'b0, 1'b0, ST_OK, 1'b0},
    '{8'd3, 1'b0, 1'b0, 1'b0, ST_OK, 1'b0},
    '{8'h00, 1'b0, 1'b0, 1'b0, ST_OK, 1'b0}, '{8'h00, 1'b0, 1'b0, 1'b0, ST_OK, 1'b0},
    '{8'd2, 1'b1, 1'b0, 1'b0, ST_OK, 1'b0}
  };

  initial begin
    logic [7:0] pkt [$];
    int sent, kind;
    sni_word_t want;
    rst_n = 1'b0;
    in_tvalid = 1'b0; in_tdata = '0; in_tlast = 1'b0; in_tuser = 1'b0;
    out_tready = 1'b0;
    mismatches = 0; quiet_cycles = 0; no_idle = 1'b0;
    clear_packet();
    repeat (9) @(negedge clk);
    rst_n = 1'b1;

    // directed table: check typed-in summaries against the predictor too
    foreach (directed[i]) begin
      send_byte(directed[i].data, directed[i].eop, directed[i].https);
      if (directed[i].has_sum) begin
        want = sni_expected[$];
        if (want.status !== directed[i].sum_status || want.is_https !== directed[i].sum_https)
        begin
          mismatches++;
          if (mismatches <= 10)
            $display("row %0d summary: expected status %0d https %0d, predicted %p",
                     i, directed[i].sum_status, directed[i].sum_https, want);
        end
      end
    end
    // a clean ClientHello with a name, and one with an overrunning name
    build_hello(pkt, 0); send_packet(pkt, 1'b1);
    build_hello(pkt, 4); send_packet(pkt, 1'b0);

    // random part: mostly well-formed hellos, some broken ones and noise
    sent = 0;
    while (sent < TARGET_BYTES) begin
      if (sent > TARGET_BYTES * 4 / 5) no_idle = 1'b1;
      kind = $urandom_range(0, 9);
      if (kind < 6) build_hello(pkt, 0);
      else if (kind < 9) build_hello(pkt, kind - 5);
      else begin
        pkt.delete();
        repeat ($urandom_range(1, 12)) pkt = {pkt, 8'($urandom)};
        if ($urandom_range(0, 1)) pkt[0] = CT_HANDSHAKE;
      end
      send_packet(pkt, 1'($urandom));
      sent += pkt.size();
    end
    in_tvalid <= 1'b0;

    while (sni_expected.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (mismatches == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule
`default_nettype wire

// ===== filelist.f =====
hdl/tse_pkg.sv
hdl/tse_parser.sv
hdl/tse_emitter.sv
hdl/tls_record_sni_extractor.sv
sim/testbench.sv
